// File: src/bttf_pkg.sv
// ----------------------------------------------------------------------------
// bttf_pkg: shared types and constants of the time-to-full estimator
// Datapath operation codes, status bundle and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package bttf_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;

  localparam int CUR_W  = 16;
  localparam int LVL_W  = 10;
  localparam int SEC_W  = 16;
  localparam int IDX_W  = 4;
  localparam int CAP_W  = 16;
  localparam int ROWS_W = 5;
  localparam int OUT_W  = 32;
  localparam int ACC_W  = 38;
  localparam int QUO_W  = 26;

  // 3600 / 1000 reduced to 18 / 5; divide by 5 through reciprocal, shift 34
  localparam logic [4:0]  CC_MUL      = 5'd18;
  localparam logic [31:0] DIV5_RECIP  = 32'hCCCC_CCCD;
  localparam logic [39:0] MIN_SECONDS = 40'd60;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_ROWS     = 1'b1;

  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NONE   = 4'd0;
  localparam dp_op_t OP_LOAD   = 4'd1;
  localparam dp_op_t OP_NEXT   = 4'd2;
  localparam dp_op_t OP_SEL    = 4'd3;
  localparam dp_op_t OP_HI     = 4'd4;
  localparam dp_op_t OP_CAPHI  = 4'd5;
  localparam dp_op_t OP_CAPLO  = 4'd6;
  localparam dp_op_t OP_CVMUL  = 4'd7;
  localparam dp_op_t OP_CCMUL  = 4'd8;
  localparam dp_op_t OP_DIVGO  = 4'd9;
  localparam dp_op_t OP_DIVCAP = 4'd10;
  localparam dp_op_t OP_M3600  = 4'd11;
  localparam dp_op_t OP_TOTAL  = 4'd12;
  localparam dp_op_t OP_DIV5   = 4'd13;

  typedef struct packed {
    logic s1_more;
    logic s2_more;
    logic is_cv;
    logic cv;
    logic fail;
    logic neg;
    logic flat;
    logic div_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// File: src/bttf_div.sv
// ----------------------------------------------------------------------------
// bttf_div: radix-2 restoring divider
// Unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bttf_div
  import bttf_pkg::*;
#(
  parameter int DW = ACC_W,
  parameter int VW = CUR_W
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               busy_o,
  output logic [DW-1:0]      quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, dvs_q, rem_d;
  logic [VW:0]   trial, diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// File: src/bttf_dp.sv
// ----------------------------------------------------------------------------
// bttf_dp: estimator datapath
// Table memory, configuration, search registers, multiply and divide steps.
// ----------------------------------------------------------------------------
`default_nettype none
module bttf_dp
  import bttf_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_index_i,
  input  wire logic [CUR_W-1:0] wr_current_i,
  input  wire logic [LVL_W-1:0] wr_level_i,
  input  wire logic [SEC_W-1:0] wr_seconds_i,
  input  wire logic [CUR_W-1:0] q_current_i,
  input  wire logic [LVL_W-1:0] q_level_i,
  input  wire dp_op_t           op_i,
  output dp_status_t            status_o,
  output logic [OUT_W-1:0]      secs_o,
  output logic                  cv_o,
  output logic                  fail_o
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  logic [CUR_W-1:0] cur_mem [TABLE_DEPTH];
  logic [LVL_W-1:0] lvl_mem [TABLE_DEPTH];
  logic [SEC_W-1:0] sec_mem [TABLE_DEPTH];

  logic [CAP_W-1:0]  cap_q;
  logic [ROWS_W-1:0] rows_q;

  logic [CUR_W-1:0] rd_cur_q, cur_q, dvs_q;
  logic [LVL_W-1:0] rd_lvl_q, lvl_q, sel_lvl_q, l_hi_q, l_lo_q;
  logic [SEC_W-1:0] rd_sec_q, sel_sec_q, t_hi_q, t_lo_q;
  logic [IW-1:0]    addr_q;
  logic [NW-1:0]    n_q, n_sel, addr_p1;
  logic [ACC_W-1:0] acc_q, quo;
  logic [OUT_W-1:0] secs_q;
  logic             cv_q, fail_q, neg_q, flat_q, div_busy;

  logic               wr_ok;
  logic [7:0]         rows_ext, depth_ext;
  logic signed [16:0] dt, cap_s;
  logic signed [10:0] dl, dd, dlv;
  logic signed [27:0] cv_prod, cc_prod;
  logic [27:0]        cv_mag, cc_mag;
  logic [10:0]        dd_mag;
  logic [39:0]        a40, tot, fin;
  logic [30:0]        m18;
  logic [62:0]        d5_prod;

  always_comb begin
    rows_ext  = {3'b0, rows_q};
    depth_ext = 8'(TABLE_DEPTH);
    n_sel     = (rows_ext > depth_ext) ? depth_ext[NW-1:0] : rows_ext[NW-1:0];
    addr_p1   = NW'(addr_q) + NW'(1);
    wr_ok     = wr_en_i && ({4'b0, wr_index_i} < depth_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= '0;
      rows_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_CAPACITY) begin
        cap_q <= cfg_wdata_i;
      end else if (cfg_index_i == REG_ROWS) begin
        rows_q <= cfg_wdata_i[ROWS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      cur_mem[IW'(wr_index_i)] <= wr_current_i;
      lvl_mem[IW'(wr_index_i)] <= wr_level_i;
      sec_mem[IW'(wr_index_i)] <= wr_seconds_i;
    end
    rd_cur_q <= cur_mem[addr_q];
    rd_lvl_q <= lvl_mem[addr_q];
    rd_sec_q <= sec_mem[addr_q];
  end

  always_comb begin
    dt      = $signed({1'b0, t_lo_q}) - $signed({1'b0, t_hi_q});
    dl      = $signed({1'b0, l_hi_q}) - $signed({1'b0, lvl_q});
    dd      = $signed({1'b0, l_hi_q}) - $signed({1'b0, l_lo_q});
    cv_prod = dt * dl;
    cv_mag  = cv_prod[27] ? 28'(-cv_prod) : 28'(cv_prod);
    dd_mag  = dd[10] ? 11'(-dd) : 11'(dd);
    cap_s   = $signed({1'b0, cap_q});
    dlv     = $signed({1'b0, sel_lvl_q}) - $signed({1'b0, lvl_q});
    cc_prod = cap_s * dlv;
    cc_mag  = cc_prod[27] ? 28'(-cc_prod) : 28'(cc_prod);
    m18     = 31'(acc_q[QUO_W-1:0]) * 31'(CC_MUL);
    d5_prod = 63'(acc_q[30:0]) * 63'(DIV5_RECIP);
    a40     = {2'b0, acc_q};
    if (cv_q) begin
      if (flat_q) begin
        tot = {24'b0, t_hi_q};
      end else begin
        tot = (neg_q ? -a40 : a40) + {24'b0, t_hi_q};
      end
    end else begin
      tot = {24'b0, sel_sec_q} + (neg_q ? 40'd0 : a40);
    end
    fin = tot[39] ? MIN_SECONDS : tot + MIN_SECONDS;
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        cur_q  <= q_current_i;
        lvl_q  <= q_level_i;
        n_q    <= n_sel;
        addr_q <= '0;
        cv_q   <= 1'b0;
        fail_q <= (q_current_i == '0) || (n_sel == '0);
      end
      OP_NEXT: addr_q <= addr_q + IW'(1);
      OP_SEL: begin
        sel_lvl_q <= rd_lvl_q;
        sel_sec_q <= rd_sec_q;
        addr_q    <= '0;
      end
      OP_HI: begin
        if (addr_q == '0 && n_q > NW'(1)) begin
          addr_q <= IW'(1);
        end
      end
      OP_CAPHI: begin
        t_hi_q <= rd_sec_q;
        l_hi_q <= rd_lvl_q;
        addr_q <= (addr_q == '0) ? '0 : addr_q - IW'(1);
      end
      OP_CAPLO: begin
        t_lo_q <= rd_sec_q;
        l_lo_q <= rd_lvl_q;
      end
      OP_CVMUL: begin
        cv_q   <= 1'b1;
        acc_q  <= ACC_W'(cv_mag);
        neg_q  <= cv_prod[27] ^ dd[10];
        flat_q <= (dd == '0);
        dvs_q  <= CUR_W'(dd_mag);
      end
      OP_CCMUL: begin
        cv_q  <= 1'b0;
        acc_q <= ACC_W'(cc_mag);
        neg_q <= cc_prod[27];
        dvs_q <= cur_q;
      end
      OP_DIVCAP: acc_q <= quo;
      OP_M3600: acc_q <= {7'b0, m18};
      OP_DIV5: acc_q <= {9'b0, d5_prod[62:34]};
      OP_TOTAL: begin
        if (fail_q) begin
          secs_q <= '0;
        end else if (fin > 40'hFFFF_FFFF) begin
          secs_q <= '1;
        end else begin
          secs_q <= fin[OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  bttf_div #(
    .DW(ACC_W),
    .VW(CUR_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (op_i == OP_DIVGO),
    .dividend_i(acc_q),
    .divisor_i (dvs_q),
    .busy_o    (div_busy),
    .quotient_o(quo)
  );

  always_comb begin
    status_o.s1_more  = (cur_q < rd_cur_q) && (addr_p1 < n_q);
    status_o.s2_more  = (lvl_q > rd_lvl_q) && (addr_p1 < n_q);
    status_o.is_cv    = sel_lvl_q < lvl_q;
    status_o.cv       = cv_q;
    status_o.fail     = fail_q;
    status_o.neg      = neg_q;
    status_o.flat     = flat_q;
    status_o.div_busy = div_busy;
  end

  assign secs_o = secs_q;
  assign cv_o   = cv_q;
  assign fail_o = fail_q;

endmodule
`default_nettype wire

// File: src/bttf_ctrl.sv
// ----------------------------------------------------------------------------
// bttf_ctrl: estimator sequencer
// Steps the datapath through table search, interpolation and division.
// ----------------------------------------------------------------------------
`default_nettype none
module bttf_ctrl
  import bttf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_fire_i,
  input  wire logic       in_query_i,
  input  wire logic       out_free_i,
  input  wire dp_status_t status_i,
  output dp_op_t          op_o,
  output logic            in_ready_o,
  output logic            out_load_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CHKF  = 5'd1;
  localparam logic [4:0] ST_S1W   = 5'd2;
  localparam logic [4:0] ST_S1C   = 5'd3;
  localparam logic [4:0] ST_PH    = 5'd4;
  localparam logic [4:0] ST_S2W   = 5'd5;
  localparam logic [4:0] ST_S2C   = 5'd6;
  localparam logic [4:0] ST_HIW   = 5'd7;
  localparam logic [4:0] ST_HIC   = 5'd8;
  localparam logic [4:0] ST_LOW   = 5'd9;
  localparam logic [4:0] ST_LOC   = 5'd10;
  localparam logic [4:0] ST_CVM   = 5'd11;
  localparam logic [4:0] ST_CVCHK = 5'd12;
  localparam logic [4:0] ST_CCCHK = 5'd13;
  localparam logic [4:0] ST_DGO1  = 5'd14;
  localparam logic [4:0] ST_DW1   = 5'd15;
  localparam logic [4:0] ST_M36   = 5'd16;
  localparam logic [4:0] ST_D5    = 5'd17;
  localparam logic [4:0] ST_TOT   = 5'd18;
  localparam logic [4:0] ST_FIN   = 5'd19;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    out_load_o = 1'b0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i && in_query_i) begin
          op_o    = OP_LOAD;
          state_d = ST_CHKF;
        end
      end
      ST_CHKF: state_d = status_i.fail ? ST_TOT : ST_S1W;
      ST_S1W:  state_d = ST_S1C;
      ST_S1C: begin
        if (status_i.s1_more) begin
          op_o    = OP_NEXT;
          state_d = ST_S1W;
        end else begin
          op_o    = OP_SEL;
          state_d = ST_PH;
        end
      end
      ST_PH: begin
        if (status_i.is_cv) begin
          state_d = ST_S2W;
        end else begin
          op_o    = OP_CCMUL;
          state_d = ST_CCCHK;
        end
      end
      ST_S2W: state_d = ST_S2C;
      ST_S2C: begin
        if (status_i.s2_more) begin
          op_o    = OP_NEXT;
          state_d = ST_S2W;
        end else begin
          op_o    = OP_HI;
          state_d = ST_HIW;
        end
      end
      ST_HIW: state_d = ST_HIC;
      ST_HIC: begin
        op_o    = OP_CAPHI;
        state_d = ST_LOW;
      end
      ST_LOW: state_d = ST_LOC;
      ST_LOC: begin
        op_o    = OP_CAPLO;
        state_d = ST_CVM;
      end
      ST_CVM: begin
        op_o    = OP_CVMUL;
        state_d = ST_CVCHK;
      end
      ST_CVCHK: state_d = status_i.flat ? ST_TOT : ST_DGO1;
      ST_CCCHK: state_d = status_i.neg ? ST_TOT : ST_DGO1;
      ST_DGO1: begin
        op_o    = OP_DIVGO;
        state_d = ST_DW1;
      end
      ST_DW1: begin
        if (!status_i.div_busy) begin
          op_o    = OP_DIVCAP;
          state_d = status_i.cv ? ST_TOT : ST_M36;
        end
      end
      ST_M36: begin
        op_o    = OP_M3600;
        state_d = ST_D5;
      end
      ST_D5: begin
        op_o    = OP_DIV5;
        state_d = ST_TOT;
      end
      ST_TOT: begin
        op_o    = OP_TOTAL;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: src/battery_time_to_full_estimator_top.sv
// ----------------------------------------------------------------------------
// battery_time_to_full_estimator_top: seconds-to-full estimator
// Constant-voltage table store plus sequenced search, interpolate and divide.
// ----------------------------------------------------------------------------
// A table write item (tuser = 0) is stored when it is taken. After a query item is
// taken the input stays closed until the result is loaded: a failed query skips
// straight to the total; otherwise the table is scanned row by row through the
// registered table read port (once in the constant-current phase, twice in the
// constant-voltage phase), with at most one pass of the bit-serial divider.
// The next item is taken once the result sits in the output register, after any
// wait for that register to empty.
`default_nettype none
module battery_time_to_full_estimator_top
  import bttf_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // row_index, row_current, row_level, row_seconds, query_current, present_level
  input  wire logic [71:0]      s_axis_tdata,
  // action
  input  wire logic [0:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // seconds_to_full
  output logic [31:0]           m_axis_tdata,
  // in_voltage_phase, failed
  output logic [1:0]            m_axis_tuser
);

  dp_status_t       status;
  dp_op_t           op;
  logic             in_fire, out_load, out_free;
  logic [OUT_W-1:0] secs;
  logic             cv, fail;
  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q;
  logic [1:0]       m_user_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  bttf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_query_i(s_axis_tuser[0]),
    .out_free_i(out_free),
    .status_i  (status),
    .op_o      (op),
    .in_ready_o(s_axis_tready),
    .out_load_o(out_load)
  );

  bttf_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .wr_en_i     (in_fire && !s_axis_tuser[0]),
    .wr_index_i  (s_axis_tdata[3:0]),
    .wr_current_i(s_axis_tdata[19:4]),
    .wr_level_i  (s_axis_tdata[29:20]),
    .wr_seconds_i(s_axis_tdata[45:30]),
    .q_current_i (s_axis_tdata[61:46]),
    .q_level_i   (s_axis_tdata[71:62]),
    .op_i        (op),
    .status_o    (status),
    .secs_o      (secs),
    .cv_o        (cv),
    .fail_o      (fail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= secs;
      m_user_q <= {fail, cv};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef ASSERT_OFF
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
    else $error("failed result carries data");

  a_min_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata >= 32'd60)
    else $error("estimate below minimum");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result overwritten");

  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_busy |-> !s_axis_tready)
    else $error("item taken during division");
`endif

endmodule
`default_nettype wire
